// File: rtl/svts_pkg.sv
// Shared types and constants for the timed servo stepper.
package svts_pkg;

    // Fixed widths of the word fields
    localparam int unsigned FINISH_W = 32;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned DRIVE_W  = 12;
    localparam int unsigned DWELL_W  = 16;

    // Reset values
    localparam int unsigned HOME_POS    = 90;
    localparam int unsigned DWELL_RESET = 500;

    // Commands from the controller to the datapath (one-hot, at most one per cycle)
    typedef struct packed {
        logic capture;
        logic tick_inc;
        logic tick_eval;
        logic set_move;
        logic set_prep;
        logic set_chk;
        logic div_step;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_set;
        logic div_skip;
        logic div_last;
    } t_status;

endpackage

// File: rtl/svts_ctrl.sv
// Sequencing state machine for the timed servo stepper.
module svts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  svts_pkg::t_status i_status,
    output svts_pkg::t_cmd    o_cmd
);
    import svts_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_START = 8'b0000_0010,
        S_EVAL  = 8'b0000_0100,
        S_PREP  = 8'b0000_1000,
        S_CHK   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_START;
                end
            end
            S_START: begin
                if (i_status.is_set) begin
                    o_cmd.set_move = 1'b1;
                    n_state        = S_PREP;
                end else begin
                    o_cmd.tick_inc = 1'b1;
                    n_state        = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.tick_eval = 1'b1;
                n_state         = S_DONE;
            end
            S_PREP: begin
                o_cmd.set_prep = 1'b1;
                n_state        = S_CHK;
            end
            S_CHK: begin
                o_cmd.set_chk = 1'b1;
                n_state       = i_status.div_skip ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result word until the far side takes it
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/svts_dp.sv
// Datapath of the timed servo stepper: motion state, step-delay divider, result register.
module svts_dp #(
    parameter int POSITION_BITS = 8,
    parameter int TIME_BITS     = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [svts_pkg::DWELL_W-1:0]   i_cfg_data,
    input  logic                           i_command,
    input  logic [svts_pkg::FINISH_W-1:0]  i_finish_time,
    input  logic [svts_pkg::POS_W-1:0]     i_middle_position,
    input  logic [svts_pkg::POS_W-1:0]     i_target_position,
    input  svts_pkg::t_cmd                 i_cmd,
    output svts_pkg::t_status              o_status,
    output logic [svts_pkg::POS_W-1:0]     o_position,
    output logic [svts_pkg::DRIVE_W-1:0]   o_drive_value,
    output logic                           o_running
);
    import svts_pkg::*;

    localparam int PW = POSITION_BITS;
    localparam int TW = TIME_BITS;
    localparam int SW = PW + 1;
    localparam int CW = $clog2(TW + 1);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TO_MID  = 2'd1,
        PH_DWELL   = 2'd2,
        PH_TO_GOAL = 2'd3
    } t_phase;

    function automatic logic [PW-1:0] step_toward(input logic [PW-1:0] cur,
                                                  input logic [PW-1:0] aim);
        logic [PW-1:0] res;
        if (cur < aim) begin
            res = cur + PW'(1);
        end else if (cur != '0) begin
            res = cur - PW'(1);
        end else begin
            res = cur;
        end
        return res;
    endfunction

    function automatic logic [PW-1:0] pos_dist(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Motion state (reset)
    logic [DWELL_W-1:0] r_dwell;
    logic [TW-1:0]      r_now, r_last, r_interval;
    logic [PW-1:0]      r_cur, r_via, r_goal;
    t_phase             r_phase;

    // Working registers (no reset)
    logic               r_is_set, r_turns, r_running;
    logic [TW-1:0]      r_finish;
    logic [PW-1:0]      r_mid, r_tgt;
    logic [SW-1:0]      r_steps;
    logic [TW:0]        r_need;
    logic [TW-1:0]      r_quo;
    logic [SW-1:0]      r_rem;
    logic [CW-1:0]      r_cnt;
    logic [POS_W-1:0]   r_out_pos;
    logic [DRIVE_W-1:0] r_out_drive;
    logic               r_out_run;

    logic [PW+POS_W-1:0]   w_mid_ext, w_tgt_ext;
    logic                  w_turns;
    logic [TW-1:0]         w_elapsed;
    logic                  w_late, w_dwell_over;
    logic [SW-1:0]         w_steps;
    logic [TW:0]           w_need;
    logic                  w_skip;
    logic [TW-1:0]         w_num;
    logic [SW:0]           w_shift, w_diff;
    logic                  w_ge;
    logic [SW-1:0]         n_rem;
    logic [TW-1:0]         n_quo;
    logic [PW+3:0]         w_prod;
    logic [PW+DRIVE_W+3:0] w_prod_ext;
    logic [PW+POS_W-1:0]   w_pos_ext;

    assign w_mid_ext = {{PW{1'b0}}, i_middle_position};
    assign w_tgt_ext = {{PW{1'b0}}, i_target_position};

    assign w_turns = ((r_cur < r_mid) && (r_mid > r_tgt)) ||
                     ((r_cur > r_mid) && (r_mid < r_tgt));

    assign w_elapsed    = r_now - r_last;
    assign w_late       = w_elapsed > r_interval;
    assign w_dwell_over = w_elapsed > TW'(r_dwell);

    assign w_steps = r_turns ? ({1'b0, pos_dist(r_mid, r_cur)} + {1'b0, pos_dist(r_tgt, r_mid)})
                             : {1'b0, pos_dist(r_tgt, r_cur)};
    assign w_need  = {1'b0, r_now} + (r_turns ? (TW + 1)'(r_dwell) : '0);

    assign w_skip = ({1'b0, r_finish} < r_need) || (r_steps == '0);
    assign w_num  = r_finish - r_need[TW-1:0];

    // Restoring divider, one quotient bit per cycle
    assign w_shift = {r_rem, r_quo[TW-1]};
    assign w_diff  = w_shift - {1'b0, r_steps};
    assign w_ge    = !w_diff[SW];
    assign n_rem   = w_ge ? w_diff[SW-1:0] : w_shift[SW-1:0];
    assign n_quo   = {r_quo[TW-2:0], w_ge};

    // Drive value: position times ten as two shifted adds
    assign w_prod     = ({4'b0, r_cur} << 3) + ({4'b0, r_cur} << 1);
    assign w_prod_ext = {{DRIVE_W{1'b0}}, w_prod};
    assign w_pos_ext  = {{POS_W{1'b0}}, r_cur};

    assign o_status.is_set   = r_is_set;
    assign o_status.div_skip = w_skip;
    assign o_status.div_last = (r_cnt == CW'(1));

    assign o_position    = r_out_pos;
    assign o_drive_value = r_out_drive;
    assign o_running     = r_out_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell    <= DWELL_W'(DWELL_RESET);
            r_now      <= '0;
            r_last     <= '0;
            r_interval <= '0;
            r_cur      <= PW'(HOME_POS);
            r_via      <= '0;
            r_goal     <= PW'(HOME_POS);
            r_phase    <= PH_IDLE;
        end else begin
            if (i_cfg_we) begin
                r_dwell <= i_cfg_data;
            end
            if (i_cmd.tick_inc) begin
                r_now <= r_now + TW'(1);
            end
            if (i_cmd.set_move) begin
                r_goal <= r_tgt;
                r_last <= r_now;
                if (w_turns) begin
                    r_via   <= r_mid;
                    r_phase <= PH_TO_MID;
                    r_cur   <= step_toward(r_cur, r_mid);
                end else begin
                    r_phase <= PH_TO_GOAL;
                    r_cur   <= step_toward(r_cur, r_tgt);
                end
            end
            if (i_cmd.set_chk && w_skip) begin
                r_interval <= '0;
            end
            if (i_cmd.div_step && o_status.div_last) begin
                r_interval <= n_quo;
            end
            if (i_cmd.tick_eval) begin
                unique case (r_phase)
                    PH_TO_MID: begin
                        if (w_late) begin
                            if (r_cur == r_via) begin
                                r_phase <= PH_DWELL;
                            end else begin
                                r_cur <= step_toward(r_cur, r_via);
                            end
                            r_last <= r_now;
                        end
                    end
                    PH_DWELL: begin
                        if (w_dwell_over) begin
                            r_phase <= PH_TO_GOAL;
                            r_last  <= r_now;
                        end
                    end
                    PH_TO_GOAL: begin
                        if (w_late) begin
                            if (r_cur == r_goal) begin
                                r_phase <= PH_IDLE;
                            end else begin
                                r_cur  <= step_toward(r_cur, r_goal);
                                r_last <= r_now;
                            end
                        end
                    end
                    PH_IDLE: begin
                        r_phase <= PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_set <= i_command;
            r_finish <= i_finish_time[TW-1:0];
            r_mid    <= w_mid_ext[PW-1:0];
            r_tgt    <= w_tgt_ext[PW-1:0];
        end
        if (i_cmd.set_move) begin
            r_turns   <= w_turns;
            r_running <= 1'b1;
        end
        if (i_cmd.tick_eval) begin
            r_running <= (r_phase != PH_IDLE) &&
                         !((r_phase == PH_TO_GOAL) && w_late && (r_cur == r_goal));
        end
        if (i_cmd.set_prep) begin
            r_steps <= w_steps;
            r_need  <= w_need;
        end
        if (i_cmd.set_chk) begin
            r_quo <= w_num;
            r_rem <= '0;
            r_cnt <= CW'(TW);
        end
        if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.load_out) begin
            r_out_pos   <= w_pos_ext[POS_W-1:0];
            r_out_drive <= w_prod_ext[DRIVE_W-1:0];
            r_out_run   <= r_running;
        end
    end

endmodule

// File: rtl/servo_via_point_timed_stepper.sv
// Top level of the timed servo stepper with via point.
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+------------------------------------
//  in       | in        | i_in_valid / o_in_stall    | command, finish time, middle, target
//  out      | out       | o_out_valid / i_out_stall  | position, drive value, running
//  cfg      | in        | i_cfg_valid / o_cfg_ready  | dwell time in ms
//
// A tick word passes through the start, evaluate and done states before its result
// reaches the result register; a set word passes through start, prep, check and the
// restoring divider, which produces one quotient bit of the step delay per cycle, or
// skips the divider when the finish is before now (plus the dwell on a turning move)
// or no steps remain. One word is worked on at a time; the next is accepted the cycle
// after the previous result drops into the output register, even while the far side
// stalls it, so a new word is not taken before the previous result is loaded.
// Reset is synchronous and active low; it homes the position, clears time and
// restores the dwell register. The input stalls and cfg is not ready during reset.
module servo_via_point_timed_stepper #(
    parameter int POSITION_BITS = 8,
    parameter int TIME_BITS     = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_command,
    input  logic [svts_pkg::FINISH_W-1:0]  i_finish_time,
    input  logic [svts_pkg::POS_W-1:0]     i_middle_position,
    input  logic [svts_pkg::POS_W-1:0]     i_target_position,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [svts_pkg::POS_W-1:0]     o_position,
    output logic [svts_pkg::DRIVE_W-1:0]   o_drive_value,
    output logic                           o_running,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [svts_pkg::DWELL_W-1:0]   i_cfg_data
);
    import svts_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_cfg_we;

    // Configuration is taken whenever reset is released
    assign o_cfg_ready = i_rst_n;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // Controller: accept a word, sequence the tick or set steps, run the
    // divider, then drop the result into the output register
    svts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath: time base, phase and position, step-delay divider, result word
    svts_dp #(
        .POSITION_BITS (POSITION_BITS),
        .TIME_BITS     (TIME_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (w_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_command         (i_command),
        .i_finish_time     (i_finish_time),
        .i_middle_position (i_middle_position),
        .i_target_position (i_target_position),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_position        (o_position),
        .o_drive_value     (o_drive_value),
        .o_running         (o_running)
    );

    // An accepted word keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    // Loading the result register always raises the output valid
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_out_valid)
        else $error("result load did not raise output valid");

    // The last divider step always hands over to the result stage
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.div_step && w_status.div_last) |=> !w_cmd.div_step)
        else $error("divider kept stepping past its last bit");

    // Drive value follows the position when the position fits the port
    a_drive_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ((POSITION_BITS > 8) ||
            (o_drive_value == (12'(o_position) << 3) + (12'(o_position) << 1))))
        else $error("drive value does not match position times ten");

endmodule
